// File: hw/rtl/asgr_pkg.sv
// Shared types and constants for the ANSI SGR attribute parser.
// No dependencies; every other file of the block imports this package.
package asgr_pkg;

  localparam int MAX_PARAM_BYTES = 14;
  localparam int CNT_W = $clog2(MAX_PARAM_BYTES + 1);
  localparam int IDX_W = $clog2(MAX_PARAM_BYTES);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_M      = 8'h6D;

  localparam logic [4:0] COLOR_DEFAULT = 5'd16;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [4:0] fg_color;
    logic [4:0] bg_color;
    logic       bold_on;
    logic       italic_on;
    logic       underline_on;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic       underline;
    logic       italic;
    logic       bold;
    logic [4:0] bg;
    logic [4:0] fg;
  } attr_t;

  localparam attr_t ATTR_DEFAULT = '{underline: 1'b0, italic: 1'b0, bold: 1'b0,
                                     bg: COLOR_DEFAULT, fg: COLOR_DEFAULT};

  typedef enum logic [2:0] {
    K_ESC,
    K_LBRACK,
    K_DIGIT,
    K_SEMI,
    K_FINAL_M,
    K_FINAL,
    K_OTHER
  } kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    kind_t      kind;
    logic       chunk_end;
  } token_t;

endpackage

// File: hw/rtl/asgr_front.sv
// Front stage: register each accepted byte and tag it with its byte class.
// Depends on asgr_pkg.
module asgr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  asgr_pkg::in_item_t in_data,
  input  logic              push,
  output logic              full,
  output asgr_pkg::token_t  tok,
  output logic              tok_valid,
  input  logic              tok_full
);
  import asgr_pkg::*;

  logic   valid_r, valid_nxt;
  token_t tok_r, tok_nxt;
  logic   accept;
  kind_t  kind;

  always_comb begin
    logic [7:0] b;
    b = in_data.text_byte;
    if (b == CH_ESC) begin
      kind = K_ESC;
    end else if (b == CH_LBRACK) begin
      kind = K_LBRACK;
    end else if (b == CH_SEMI) begin
      kind = K_SEMI;
    end else if (b == CH_M) begin
      kind = K_FINAL_M;
    end else if (b inside {[8'h30:8'h39]}) begin
      kind = K_DIGIT;
    end else if (b inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
      kind = K_FINAL;
    end else begin
      kind = K_OTHER;
    end
  end

  assign full      = valid_r && tok_full;
  assign accept    = push && !full;
  assign tok       = tok_r;
  assign tok_valid = valid_r;

  always_comb begin
    valid_nxt = valid_r;
    tok_nxt   = tok_r;
    if (accept) begin
      valid_nxt = 1'b1;
      tok_nxt   = '{text_byte: in_data.text_byte, kind: kind,
                    chunk_end: in_data.chunk_end};
    end else if (valid_r && !tok_full) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    tok_r <= tok_nxt;
  end

endmodule

// File: hw/rtl/asgr_fifo.sv
// Short token queue between the front stage and the sequence engine.
// Depends on asgr_pkg for the token type and depth.
module asgr_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  asgr_pkg::token_t wr_tok,
  input  logic             wr_en,
  output logic             q_full,
  output asgr_pkg::token_t rd_tok,
  output logic             q_valid,
  input  logic             rd_en
);
  import asgr_pkg::*;

  token_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_wr, do_rd;

  assign q_full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign rd_tok  = mem[rd_ptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (do_wr) mem[wr_ptr_r] <= wr_tok;
  end

endmodule

// File: hw/rtl/asgr_engine.sv
// Sequence engine: run the escape parser on queued tokens, apply SGR codes,
// replay broken sequences byte by byte and drive the result register.
// Depends on asgr_pkg.
module asgr_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  asgr_pkg::token_t   q_tok,
  input  logic               q_valid,
  output logic               q_pop,
  output asgr_pkg::out_item_t out_data,
  output logic               empty,
  input  logic               pop
);
  import asgr_pkg::*;

  typedef enum logic [1:0] {M_TEXT, M_ESC, M_PARAM} mode_t;
  typedef enum logic [2:0] {S_RUN, S_REPROC, S_FL_ESC, S_FL_LB, S_FL_PRM} state_t;

  function automatic attr_t apply_code(attr_t a, logic [7:0] c);
    attr_t r;
    r = a;
    case (c) inside
      8'd0:          r = ATTR_DEFAULT;
      8'd1:          r.bold = 1'b1;
      8'd2:          r.bold = 1'b0;
      8'd3:          r.italic = 1'b1;
      8'd4:          r.underline = 1'b1;
      [8'd30:8'd37]:   r.fg = 5'(c - 8'd30);
      [8'd90:8'd97]:   r.fg = 5'(c - 8'd82);
      [8'd40:8'd47]:   r.bg = 5'(c - 8'd40);
      [8'd100:8'd107]: r.bg = 5'(c - 8'd92);
      default:       r = a;
    endcase
    return r;
  endfunction

  state_t           state_r, state_nxt;
  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [7:0]       accum_r, accum_nxt;
  attr_t            commit_r, commit_nxt;
  attr_t            staged_r, staged_nxt;
  token_t           tok_r, tok_nxt;
  logic             reproc_r, reproc_nxt;
  logic [7:0]       store [MAX_PARAM_BYTES];
  logic             st_we;
  logic [7:0]       st_data;
  logic             ovalid_r, ovalid_nxt;
  out_item_t        oitem_r, oitem_nxt;

  logic             ofree;
  logic             emit;
  logic [7:0]       emit_ch;
  logic             emit_last;
  token_t           cur;

  assign ofree    = !ovalid_r || pop;
  assign empty    = !ovalid_r;
  assign out_data = oitem_r;
  assign cur      = (state_r == S_RUN) ? q_tok : tok_r;

  always_comb begin
    logic       brk;
    logic       flush_done;
    logic [11:0] v;
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    accum_nxt  = accum_r;
    commit_nxt = commit_r;
    staged_nxt = staged_r;
    tok_nxt    = tok_r;
    reproc_nxt = reproc_r;
    st_we      = 1'b0;
    st_data    = cur.text_byte;
    emit       = 1'b0;
    emit_ch    = cur.text_byte;
    emit_last  = 1'b0;
    q_pop      = 1'b0;
    brk        = 1'b0;
    flush_done = 1'b0;
    v          = '0;

    case (state_r)
      S_RUN, S_REPROC: begin
        if (ofree && (state_r == S_REPROC || q_valid)) begin
          q_pop   = (state_r == S_RUN);
          tok_nxt = cur;
          case (mode_r)
            M_ESC: begin
              if (cur.kind == K_LBRACK) begin
                mode_nxt   = M_PARAM;
                count_nxt  = '0;
                accum_nxt  = '0;
                staged_nxt = commit_r;
              end else begin
                brk = 1'b1;
              end
            end
            M_PARAM: begin
              if (cur.kind == K_DIGIT || cur.kind == K_SEMI) begin
                if (count_r >= CNT_W'(MAX_PARAM_BYTES)) begin
                  brk = 1'b1;
                end else begin
                  st_we     = 1'b1;
                  count_nxt = count_r + 1'b1;
                  if (cur.kind == K_DIGIT) begin
                    v = 12'(accum_r) * 12'd10 + 12'(cur.text_byte - 8'h30);
                    accum_nxt = (v > 12'd255) ? 8'd255 : v[7:0];
                  end else begin
                    staged_nxt = apply_code(staged_r, accum_r);
                    accum_nxt  = '0;
                  end
                end
              end else if (cur.kind == K_FINAL_M || cur.kind == K_FINAL) begin
                if (cur.kind == K_FINAL_M) begin
                  commit_nxt = apply_code(staged_r, accum_r);
                  staged_nxt = commit_nxt;
                end else begin
                  staged_nxt = commit_r;
                end
                mode_nxt  = M_TEXT;
                count_nxt = '0;
                accum_nxt = '0;
              end else begin
                brk = 1'b1;
              end
            end
            default: begin
              mode_nxt = M_TEXT;
              if (cur.kind == K_ESC) begin
                mode_nxt = M_ESC;
              end else begin
                emit      = 1'b1;
                emit_last = 1'b1;
              end
            end
          endcase
          // Drop to replay on a break; otherwise close the chunk if marked.
          if (brk) begin
            state_nxt  = S_FL_ESC;
            reproc_nxt = 1'b1;
          end else if (cur.chunk_end && mode_nxt != M_TEXT) begin
            state_nxt  = S_FL_ESC;
            reproc_nxt = 1'b0;
          end else begin
            state_nxt = S_RUN;
            if (cur.chunk_end) begin
              commit_nxt = ATTR_DEFAULT;
              staged_nxt = ATTR_DEFAULT;
            end
          end
        end
      end
      S_FL_ESC: begin
        if (ofree) begin
          emit    = 1'b1;
          emit_ch = CH_ESC;
          if (mode_r == M_PARAM) begin
            state_nxt = S_FL_LB;
          end else begin
            flush_done = 1'b1;
          end
        end
      end
      S_FL_LB: begin
        if (ofree) begin
          emit    = 1'b1;
          emit_ch = CH_LBRACK;
          idx_nxt = '0;
          if (count_r == '0) begin
            flush_done = 1'b1;
          end else begin
            state_nxt = S_FL_PRM;
          end
        end
      end
      S_FL_PRM: begin
        if (ofree) begin
          emit    = 1'b1;
          emit_ch = store[idx_r[IDX_W-1:0]];
          idx_nxt = idx_r + 1'b1;
          if (idx_nxt == count_r) flush_done = 1'b1;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase

    if (flush_done) begin
      // A replayed byte in text mode emits unless it opens a new escape.
      emit_last  = reproc_r ? (tok_r.kind == K_ESC && !tok_r.chunk_end) : 1'b1;
      mode_nxt   = M_TEXT;
      count_nxt  = '0;
      accum_nxt  = '0;
      staged_nxt = commit_r;
      if (reproc_r) begin
        state_nxt = S_REPROC;
      end else begin
        state_nxt  = S_RUN;
        commit_nxt = ATTR_DEFAULT;
        staged_nxt = ATTR_DEFAULT;
      end
    end

    ovalid_nxt = ovalid_r;
    oitem_nxt  = oitem_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      oitem_nxt  = '{out_char: emit_ch, fg_color: commit_r.fg, bg_color: commit_r.bg,
                     bold_on: commit_r.bold, italic_on: commit_r.italic,
                     underline_on: commit_r.underline, run_last: emit_last};
    end else if (pop) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_RUN;
      mode_r   <= M_TEXT;
      count_r  <= '0;
      idx_r    <= '0;
      accum_r  <= '0;
      commit_r <= ATTR_DEFAULT;
      staged_r <= ATTR_DEFAULT;
      reproc_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      accum_r  <= accum_nxt;
      commit_r <= commit_nxt;
      staged_r <= staged_nxt;
      reproc_r <= reproc_nxt;
      ovalid_r <= ovalid_nxt;
    end
    tok_r   <= tok_nxt;
    oitem_r <= oitem_nxt;
    if (st_we) store[count_r[IDX_W-1:0]] <= st_data;
  end

endmodule

// File: hw/rtl/ansi_sgr_attribute_parser.sv
// ANSI SGR attribute parser, top level: byte classifier, token queue, engine.
// Depends on asgr_pkg, asgr_front, asgr_fifo and asgr_engine.
// Path: front register, token queue, then the engine's result register on out_data.
// Throughput: 1 byte per cycle while the engine stays in text or parameters and
//   out_data is not held; a broken sequence replays ESC (and '[' with its stored
//   bytes once '[' was seen) at one per cycle, then reruns the breaking byte.
// Reset: synchronous, active low; text mode, default colours, queues empty.
module ansi_sgr_attribute_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  asgr_pkg::in_item_t  in_data,
  input  logic                push,
  output logic                full,
  output asgr_pkg::out_item_t out_data,
  output logic                empty,
  input  logic                pop
);
  import asgr_pkg::*;

  // Front to queue: one classified token per accepted byte.
  token_t f_tok;
  logic   f_valid;
  logic   q_full;

  // Queue to engine: head token, popped when the engine consumes it.
  token_t q_tok;
  logic   q_valid;
  logic   q_pop;

  // Classify bytes; hold the front register while the queue is full.
  asgr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .push     (push),
    .full     (full),
    .tok      (f_tok),
    .tok_valid(f_valid),
    .tok_full (q_full)
  );

  // Absorb the cycles the engine spends replaying a broken sequence.
  asgr_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_tok (f_tok),
    .wr_en  (f_valid),
    .q_full (q_full),
    .rd_tok (q_tok),
    .q_valid(q_valid),
    .rd_en  (q_pop)
  );

  // Parse, apply attributes and drive the result register.
  asgr_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_tok   (q_tok),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_data(out_data),
    .empty   (empty),
    .pop     (pop)
  );

endmodule
